>>> rtl/sqlx_pkg.sv
`timescale 1ns / 1ps
package sqlx_pkg;

   // Token kinds as they appear on the result channel
   localparam logic [3:0] KIND_BYTE    = 4'd0;
   localparam logic [3:0] KIND_TEND    = 4'd1;
   localparam logic [3:0] KIND_OR      = 4'd2;
   localparam logic [3:0] KIND_AND     = 4'd3;
   localparam logic [3:0] KIND_AND_NOT = 4'd4;
   localparam logic [3:0] KIND_NOT     = 4'd5;
   localparam logic [3:0] KIND_LPAREN  = 4'd6;
   localparam logic [3:0] KIND_RPAREN  = 4'd7;
   localparam logic [3:0] KIND_END     = 4'd8;

   localparam logic [2:0] LAST_START = 3'd0;

   // Byte codes
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_BAR    = 8'h7c;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] LEAD_D0   = 8'hd0;
   localparam logic [7:0] LEAD_D1   = 8'hd1;
   localparam logic [7:0] LEAD_CC   = 8'hcc;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_AMP,
      HOLD_BAR,
      HOLD_LEAD
   } hold_kind_type;

   typedef struct packed {
      logic [7:0] query_byte;
      logic       end_of_request;
   } req_type;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] term_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] value;
   } token_entry_type;

   typedef struct packed {
      logic [1:0]                             count;
      token_entry_type [MAX_RESULTS-1:0]      tok;
   } bundle_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // Append one token to a bundle; term_byte is zero for non-byte kinds
   function automatic bundle_type bundle_push(bundle_type b, logic [3:0] k, logic [7:0] v);
      bundle_type r;
      r = b;
      if (b.count < 2'(MAX_RESULTS)) begin
         r.tok[b.count].kind  = k;
         r.tok[b.count].value = (k == KIND_BYTE) ? v : 8'h00;
         r.count              = b.count + 2'd1;
      end
      return r;
   endfunction

endpackage

>>> rtl/sqlx_front.sv
`timescale 1ns / 1ps
module sqlx_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  sqlx_pkg::req_type          req_data,
   input  sqlx_pkg::queue_status_type q_status,
   output logic                       req_stall,
   output logic                       push,
   output sqlx_pkg::bundle_type       push_data
);
   import sqlx_pkg::*;

   logic [7:0]    held_byte_ff, held_byte_in;
   hold_kind_type hold_kind_ff, hold_kind_in;
   logic          term_open_ff, term_open_in;
   logic [2:0]    last_token_ff, last_token_in;
   logic          and_pending_ff, and_pending_in;

   logic       accept;
   logic [7:0] b;
   logic       is_ascii_word, is_upper, is_lead, is_cont;
   logic       close_req, op_req;
   logic [1:0] word_cnt;
   logic [7:0] wb0, wb1;
   logic [3:0] op_k;
   bundle_type bnd;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign b         = req_data.query_byte;

   assign is_upper      = (b >= 8'h41) && (b <= 8'h5a);
   assign is_ascii_word = is_upper || ((b >= 8'h61) && (b <= 8'h7a)) ||
                          ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_UNDER);
   assign is_lead       = (b == LEAD_D0) || (b == LEAD_D1) || (b == LEAD_CC);

   always_comb begin
      priority if (held_byte_ff == LEAD_D0) is_cont = (b >= 8'h80) && (b <= 8'hbf);
      else if (held_byte_ff == LEAD_D1)     is_cont = (b >= 8'h80) && (b <= 8'h9f);
      else if (held_byte_ff == LEAD_CC)     is_cont = (b >= 8'h80) && (b <= 8'hbb);
      else                                  is_cont = 1'b0;
   end

   always_comb begin
      bnd            = '0;
      held_byte_in   = held_byte_ff;
      hold_kind_in   = hold_kind_ff;
      term_open_in   = term_open_ff;
      last_token_in  = last_token_ff;
      and_pending_in = and_pending_ff;
      close_req      = 1'b0;
      op_req         = 1'b0;
      op_k           = KIND_AND;
      word_cnt       = 2'd0;
      wb0            = 8'h00;
      wb1            = 8'h00;

      if (req_data.end_of_request) begin
         if (term_open_ff) bnd = bundle_push(bnd, KIND_TEND, 8'h00);
         if (and_pending_ff) bnd = bundle_push(bnd, KIND_AND, 8'h00);
         bnd            = bundle_push(bnd, KIND_END, 8'h00);
         held_byte_in   = 8'h00;
         hold_kind_in   = HOLD_NONE;
         term_open_in   = 1'b0;
         last_token_in  = LAST_START;
         and_pending_in = 1'b0;
      end else begin
         held_byte_in = 8'h00;
         hold_kind_in = HOLD_NONE;
         // decode what this byte does
         priority if (hold_kind_ff == HOLD_AMP && b == CH_AMP) begin
            op_req = 1'b1;
            op_k   = KIND_AND;
         end else if (hold_kind_ff == HOLD_BAR && b == CH_BAR) begin
            op_req = 1'b1;
            op_k   = KIND_OR;
         end else if (hold_kind_ff == HOLD_LEAD && is_cont) begin
            // fold Cyrillic capitals to lowercase, drop combining marks
            if (held_byte_ff == LEAD_CC) begin
               word_cnt = 2'd0;
            end else begin
               word_cnt = 2'd2;
               wb0      = held_byte_ff;
               wb1      = b;
               if (held_byte_ff == LEAD_D0) begin
                  priority if (b <= 8'h8f) begin
                     wb0 = LEAD_D1;
                     wb1 = b + 8'h10;
                  end else if (b <= 8'h9f) begin
                     wb1 = b + 8'h20;
                  end else if (b <= 8'haf) begin
                     wb0 = LEAD_D1;
                     wb1 = b - 8'h20;
                  end else begin
                     wb1 = b;
                  end
               end
            end
            // open even for a bare combining mark
            if (!term_open_in) begin
               if (and_pending_in) begin
                  bnd            = bundle_push(bnd, KIND_AND, 8'h00);
                  and_pending_in = 1'b0;
               end
               term_open_in = 1'b1;
            end
         end else begin
            if (hold_kind_ff == HOLD_LEAD) close_req = 1'b1;
            if (is_ascii_word) begin
               word_cnt = 2'd1;
               wb0      = is_upper ? b + 8'h20 : b;
            end else if (is_lead) begin
               held_byte_in = b;
               hold_kind_in = HOLD_LEAD;
            end else begin
               close_req = 1'b1;
               unique case (b)
                  CH_AMP: begin
                     held_byte_in = b;
                     hold_kind_in = HOLD_AMP;
                  end
                  CH_BAR: begin
                     held_byte_in = b;
                     hold_kind_in = HOLD_BAR;
                  end
                  CH_SPACE: begin
                     op_req = 1'b1;
                     op_k   = KIND_AND;
                  end
                  CH_BANG: begin
                     op_req = 1'b1;
                     op_k   = KIND_NOT;
                  end
                  CH_LPAREN: begin
                     op_req = 1'b1;
                     op_k   = KIND_LPAREN;
                  end
                  CH_RPAREN: begin
                     op_req = 1'b1;
                     op_k   = KIND_RPAREN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // close, then word bytes, then operator
         if (close_req && term_open_in) begin
            bnd           = bundle_push(bnd, KIND_TEND, 8'h00);
            term_open_in  = 1'b0;
            last_token_in = KIND_TEND[2:0];
         end
         if (word_cnt == 2'd1) begin
            if (!term_open_in) begin
               if (and_pending_in) begin
                  bnd            = bundle_push(bnd, KIND_AND, 8'h00);
                  and_pending_in = 1'b0;
               end
               term_open_in = 1'b1;
            end
            bnd = bundle_push(bnd, KIND_BYTE, wb0);
         end else if (word_cnt == 2'd2) begin
            bnd = bundle_push(bnd, KIND_BYTE, wb0);
            bnd = bundle_push(bnd, KIND_BYTE, wb1);
         end
         if (op_req) begin
            if (op_k == KIND_AND) begin
               if (!and_pending_in && (last_token_in == KIND_TEND[2:0] ||
                                       last_token_in == KIND_RPAREN[2:0])) begin
                  and_pending_in = 1'b1;
                  last_token_in  = KIND_AND[2:0];
               end
            end else if (and_pending_in && op_k == KIND_OR) begin
               and_pending_in = 1'b0;
               bnd            = bundle_push(bnd, KIND_OR, 8'h00);
               last_token_in  = KIND_OR[2:0];
            end else if (and_pending_in && op_k == KIND_NOT) begin
               and_pending_in = 1'b0;
               bnd            = bundle_push(bnd, KIND_AND_NOT, 8'h00);
               last_token_in  = KIND_AND_NOT[2:0];
            end else begin
               if (and_pending_in) begin
                  and_pending_in = 1'b0;
                  bnd            = bundle_push(bnd, KIND_AND, 8'h00);
               end
               bnd           = bundle_push(bnd, op_k, 8'h00);
               last_token_in = op_k[2:0];
            end
         end
      end
   end

   assign push      = accept && (bnd.count != 2'd0);
   assign push_data = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff   <= 8'h00;
         hold_kind_ff   <= HOLD_NONE;
         term_open_ff   <= 1'b0;
         last_token_ff  <= LAST_START;
         and_pending_ff <= 1'b0;
      end else if (accept) begin
         held_byte_ff   <= held_byte_in;
         hold_kind_ff   <= hold_kind_in;
         term_open_ff   <= term_open_in;
         last_token_ff  <= last_token_in;
         and_pending_ff <= and_pending_in;
      end
   end

endmodule

>>> rtl/sqlx_queue.sv
`timescale 1ns / 1ps
module sqlx_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sqlx_pkg::bundle_type       push_data,
   input  logic                       pop,
   output sqlx_pkg::bundle_type       head,
   output sqlx_pkg::queue_status_type status
);
   import sqlx_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign status.not_empty = (cnt_ff != '0);
   assign status.full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head             = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_data;
   end

endmodule

>>> rtl/sqlx_emit.sv
`timescale 1ns / 1ps
module sqlx_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  sqlx_pkg::bundle_type       head,
   input  sqlx_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sqlx_pkg::rsp_type          rsp_data
);
   import sqlx_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       taken, is_last;

   assign rsp_valid            = q_status.not_empty;
   assign is_last              = (idx_ff == head.count - 2'd1);
   assign taken                = rsp_valid && !rsp_stall;
   assign pop                  = taken && is_last;
   assign rsp_data.token_kind  = head.tok[idx_ff].kind;
   assign rsp_data.term_byte   = head.tok[idx_ff].value;
   assign rsp_data.last_of_run = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (taken) idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> rtl/search_query_lexer_unit.sv
`timescale 1ns / 1ps
// Search query lexer: one query byte per request beat, zero to three tokens out.
// The front's token bundle is registered in the bundle queue before its first token is on rsp.
// Throughput: one byte per cycle while bytes give at most one token and rsp is not
// stalled; the tokens of a byte leave one per beat on the single result port.
// Reset (synchronous, active high) clears the lexer state and empties the queue.
module search_query_lexer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sqlx_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sqlx_pkg::rsp_type rsp_data
);
   import sqlx_pkg::*;

   // Front: classify each byte, update lexer state, build its token bundle.
   // Bytes that give no token leave nothing in the queue.
   logic             push;
   bundle_type       push_data;
   bundle_type       head;
   queue_status_type q_status;
   logic             pop;

   sqlx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_status  (q_status),
      .req_stall (req_stall),
      .push      (push),
      .push_data (push_data)
   );

   // Short bundle queue: decouple the front from a stalled result side
   sqlx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // Back: walk the head bundle one token per beat, flag the last one
   sqlx_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
